### rtl/hlfd_pkg.sv
// Shared types and codes for the hand link framer and deframer.
`default_nettype none
package hlfd_pkg;

  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned MaxTxBytes  = 5;

  localparam logic [7:0] SpeedMinReset = 8'h31;
  localparam logic [7:0] SpeedMaxReset = 8'h85;

  localparam logic MODE_COMMAND = 1'b0;
  localparam logic MODE_BYTE    = 1'b1;

  localparam logic [2:0] CMD_START_DUMP = 3'd0;
  localparam logic [2:0] CMD_STOP_DUMP  = 3'd1;
  localparam logic [2:0] CMD_OPEN       = 3'd2;
  localparam logic [2:0] CMD_CLOSE      = 3'd3;
  localparam logic [2:0] CMD_STOP       = 3'd4;
  localparam logic [2:0] CMD_SERIAL     = 3'd5;
  localparam logic [2:0] CMD_RESET      = 3'd6;
  localparam logic [2:0] CMD_PROGRAM    = 3'd7;

  localparam logic [7:0] OP_START_DUMP = 8'h73;
  localparam logic [7:0] OP_STOP_DUMP  = 8'h7a;
  localparam logic [7:0] OP_DRIVE      = 8'h75;
  localparam logic [7:0] OP_SERIAL     = 8'h76;
  localparam logic [7:0] OP_RESET      = 8'h6d;
  localparam logic [7:0] OP_PROGRAM    = 8'h61;
  localparam logic [7:0] DUMP_MARK     = 8'hff;

  localparam logic [1:0] KIND_TX      = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  localparam logic [2:0] STATUS_OK       = 3'd0;
  localparam logic [2:0] STATUS_DUMP     = 3'd1;
  localparam logic [2:0] STATUS_CHECKSUM = 3'd2;
  localparam logic [2:0] STATUS_LENGTH   = 3'd3;
  localparam logic [2:0] STATUS_CONTENT  = 3'd4;

  localparam logic CFG_SPEED_MIN = 1'b0;
  localparam logic CFG_SPEED_MAX = 1'b1;

  typedef struct packed {
    logic [1:0]                  kind;
    logic [2:0]                  last_idx;
    logic [MaxTxBytes-1:0][7:0]  bytes;
    logic                        is_dump;
    logic [2:0]                  status;
    logic [7:0]                  frame_length;
  } job_t;

endpackage
`default_nettype wire

### rtl/hlfd_front.sv
// Front end: takes items, frames commands, deframes received bytes into jobs.
`default_nettype none
module hlfd_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_index,
  input  wire logic [7:0]   cfg_data,
  input  wire logic         in_valid,
  input  wire logic         in_ready,
  input  wire logic         mode,
  input  wire logic [2:0]   command,
  input  wire logic [7:0]   speed,
  input  wire logic [7:0]   program_value,
  input  wire logic [7:0]   rx_byte,
  output hlfd_pkg::job_t    push_job,
  output logic              push
);
  import hlfd_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FIRST = 3'd1;
  localparam logic [2:0] ST_LEN   = 3'd2;
  localparam logic [2:0] ST_DATA  = 3'd3;
  localparam logic [2:0] ST_CS    = 3'd4;

  logic [7:0] speed_min, speed_max;
  logic [2:0] link_state, link_state_next;
  logic       dump_enabled, dump_enabled_next;
  logic       frame_is_dump, frame_is_dump_next;
  logic [7:0] rx_length, rx_length_next;
  logic [7:0] rx_count, rx_count_next;
  logic [7:0] rx_checksum, rx_checksum_next;
  logic [7:0] rx_first, rx_first_next;
  logic [7:0] expected_length, expected_length_next;
  logic       check_content, check_content_next;
  logic       content_mismatch, content_mismatch_next;
  logic [7:0] expected_bytes [2];
  logic       eb0_we, eb1_we;
  logic [7:0] eb0_next, eb1_next;

  logic        accept;
  logic [7:0]  diff, quot, code;
  logic [15:0] prod;
  logic [16:0] quot_sum;
  logic        rising;

  assign accept   = in_valid && in_ready;
  assign rising   = speed_max >= speed_min;
  assign diff     = rising ? (speed_max - speed_min) : (speed_min - speed_max);
  assign prod     = {8'd0, speed} * {8'd0, diff};
  assign quot_sum = {1'b0, prod} + {9'd0, prod[15:8]} + 17'd1;
  assign quot     = quot_sum[15:8];
  assign code     = rising ? (speed_min + quot) : (speed_min - quot);

  always_comb begin
    logic [7:0] op, b2, b3, n, cs, b, sum;
    logic [8:0] cnt_inc;
    logic       d, hunt_dump;
    logic [2:0] st;
    op = OP_PROGRAM; b2 = 8'd0; b3 = 8'd0; n = 8'd2; cs = 8'd0; b = rx_byte;
    sum = 8'd0; cnt_inc = 9'd0; d = 1'b0; hunt_dump = dump_enabled; st = STATUS_OK;

    link_state_next       = link_state;
    dump_enabled_next     = dump_enabled;
    frame_is_dump_next    = frame_is_dump;
    rx_length_next        = rx_length;
    rx_count_next         = rx_count;
    rx_checksum_next      = rx_checksum;
    rx_first_next         = rx_first;
    expected_length_next  = expected_length;
    check_content_next    = check_content;
    content_mismatch_next = content_mismatch;
    eb0_we = 1'b0; eb1_we = 1'b0; eb0_next = 8'd0; eb1_next = 8'd0;
    push = 1'b0;
    push_job = '0;

    if (accept && mode == MODE_COMMAND) begin
      check_content_next   = 1'b1;
      expected_length_next = 8'd2;
      case (command)
        CMD_START_DUMP: begin op = OP_START_DUMP; eb0_we = 1'b1; eb0_next = op; end
        CMD_STOP_DUMP:  begin op = OP_STOP_DUMP;  eb0_we = 1'b1; eb0_next = op; end
        CMD_OPEN:       begin op = OP_DRIVE; b2 = code; n = 8'd4; end
        CMD_CLOSE:      begin op = OP_DRIVE; b3 = code; n = 8'd4; end
        CMD_STOP:       begin op = OP_DRIVE; n = 8'd4; end
        CMD_SERIAL: begin
          op = OP_SERIAL; expected_length_next = 8'd8; check_content_next = 1'b0;
        end
        CMD_RESET:      begin op = OP_RESET; eb0_we = 1'b1; eb0_next = op; end
        default: begin
          op = OP_PROGRAM; b2 = program_value; n = 8'd3;
          expected_length_next = 8'd3;
          eb0_we = 1'b1; eb0_next = op; eb1_we = 1'b1; eb1_next = program_value;
        end
      endcase
      if (n == 8'd4) begin
        expected_length_next = 8'd3;
        eb0_we = 1'b1; eb0_next = b2;
        eb1_we = 1'b1; eb1_next = b3;
      end
      cs = n + op + b2 + b3;
      push = 1'b1;
      push_job.kind     = KIND_TX;
      push_job.last_idx = n[2:0];
      push_job.bytes[0] = n;
      push_job.bytes[1] = op;
      push_job.bytes[2] = (n == 8'd2) ? cs : b2;
      push_job.bytes[3] = (n == 8'd3) ? cs : b3;
      push_job.bytes[4] = cs;
      link_state_next       = ST_FIRST;
      frame_is_dump_next    = 1'b0;
      rx_length_next        = 8'd0;
      rx_count_next         = 8'd0;
      rx_checksum_next      = 8'd0;
      content_mismatch_next = 1'b0;
      rx_first_next         = 8'd0;
    end else if (accept) begin
      case (link_state)
        ST_FIRST, ST_LEN: begin
          d = (link_state == ST_LEN) ? frame_is_dump : 1'b0;
          if (link_state == ST_FIRST && b == DUMP_MARK) begin
            frame_is_dump_next = 1'b1;
            link_state_next    = ST_LEN;
          end else begin
            frame_is_dump_next = d;
            if (b == 8'd0) begin
              rx_length_next        = 8'd0;
              push                  = 1'b1;
              push_job.kind         = KIND_END;
              push_job.is_dump      = d;
              push_job.status       = STATUS_LENGTH;
              link_state_next       = dump_enabled ? ST_FIRST : ST_IDLE;
            end else begin
              rx_length_next        = b;
              rx_count_next         = 8'd0;
              rx_checksum_next      = b;
              content_mismatch_next = 1'b0;
              rx_first_next         = 8'd0;
              link_state_next       = (b == 8'd1) ? ST_CS : ST_DATA;
            end
          end
        end
        ST_DATA: begin
          if (rx_count == 8'd0) rx_first_next = b;
          if (rx_count[7:1] == 7'd0 && b != expected_bytes[rx_count[0]])
            content_mismatch_next = 1'b1;
          rx_checksum_next = rx_checksum + b;
          rx_count_next    = rx_count + 8'd1;
          cnt_inc          = {1'b0, rx_count_next} + 9'd1;
          if (cnt_inc >= {1'b0, rx_length}) link_state_next = ST_CS;
          push                  = 1'b1;
          push_job.kind         = KIND_PAYLOAD;
          push_job.bytes[0]     = b;
          push_job.is_dump      = frame_is_dump;
          push_job.frame_length = rx_length;
        end
        ST_CS: begin
          sum = rx_checksum;
          if (b != sum) begin
            st = STATUS_CHECKSUM;
          end else begin
            if (rx_length == 8'd2 && rx_first == OP_START_DUMP) hunt_dump = 1'b1;
            if (rx_length == 8'd2 && rx_first == OP_STOP_DUMP)  hunt_dump = 1'b0;
            if (frame_is_dump && hunt_dump)          st = STATUS_DUMP;
            else if (rx_length != expected_length)   st = STATUS_LENGTH;
            else if (check_content && content_mismatch) st = STATUS_CONTENT;
            else                                     st = STATUS_OK;
          end
          dump_enabled_next     = hunt_dump;
          push                  = 1'b1;
          push_job.kind         = KIND_END;
          push_job.is_dump      = frame_is_dump;
          push_job.status       = st;
          push_job.frame_length = rx_length;
          link_state_next       = hunt_dump ? ST_FIRST : ST_IDLE;
        end
        default: begin
          link_state_next = link_state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_min        <= SpeedMinReset;
      speed_max        <= SpeedMaxReset;
      link_state       <= ST_IDLE;
      dump_enabled     <= 1'b0;
      frame_is_dump    <= 1'b0;
      rx_length        <= 8'd0;
      rx_count         <= 8'd0;
      rx_checksum      <= 8'd0;
      rx_first         <= 8'd0;
      expected_length  <= 8'd0;
      check_content    <= 1'b0;
      content_mismatch <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == CFG_SPEED_MIN) speed_min <= cfg_data;
      if (cfg_valid && cfg_index == CFG_SPEED_MAX) speed_max <= cfg_data;
      link_state       <= link_state_next;
      dump_enabled     <= dump_enabled_next;
      frame_is_dump    <= frame_is_dump_next;
      rx_length        <= rx_length_next;
      rx_count         <= rx_count_next;
      rx_checksum      <= rx_checksum_next;
      rx_first         <= rx_first_next;
      expected_length  <= expected_length_next;
      check_content    <= check_content_next;
      content_mismatch <= content_mismatch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (eb0_we) expected_bytes[0] <= eb0_next;
    if (eb1_we) expected_bytes[1] <= eb1_next;
  end

endmodule
`default_nettype wire

### rtl/hlfd_queue.sv
// Short job queue between the front end and the back end.
`default_nettype none
module hlfd_queue #(
  parameter int unsigned DEPTH = hlfd_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  hlfd_pkg::job_t   push_job,
  output logic             push_ready,
  input  wire logic        pop,
  output hlfd_pkg::job_t   head_job,
  output logic             head_valid
);
  import hlfd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign head_valid = count != '0;
  assign head_job   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)      count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_job;
  end

endmodule
`default_nettype wire

### rtl/hlfd_back.sv
// Back end: holds one job and plays its words out on the result channel.
`default_nettype none
module hlfd_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  hlfd_pkg::job_t   head_job,
  input  wire logic        head_valid,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       byte_value,
  output logic             last,
  output logic             is_dump,
  output logic [2:0]       status,
  output logic [7:0]       frame_length
);
  import hlfd_pkg::*;

  job_t       cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic       at_end, done;

  assign at_end = idx == cur.last_idx;
  assign done   = cur_valid && out_ready && at_end;
  assign pop    = head_valid && (!cur_valid || done);

  assign out_valid    = cur_valid;
  assign kind         = cur.kind;
  assign byte_value   = (cur.kind == KIND_END) ? 8'd0 : cur.bytes[idx];
  assign last         = (cur.kind == KIND_TX) && at_end;
  assign is_dump      = cur.is_dump;
  assign status       = cur.status;
  assign frame_length = cur.frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 3'd0;
    end else if (done) begin
      cur_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (cur_valid && out_ready) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head_job;
  end

endmodule
`default_nettype wire

### rtl/hand_link_framer_deframer.sv
// Top level of the hand link framer and deframer.
// Path: item, job queue, back end job register, result port.
// Throughput: one received byte per cycle while the job queue has room; a
// command plays out three to five result words, one per framed byte.
// Reset: rst clears link and queue state and loads speed codes 0x31 and 0x85.
`default_nettype none
module hand_link_framer_deframer #(
  parameter int unsigned QUEUE_DEPTH = hlfd_pkg::QueueDepth
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        mode,
  input  wire logic [2:0]  command,
  input  wire logic [7:0]  speed,
  input  wire logic [7:0]  program_value,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       byte_value,
  output logic             last,
  output logic             is_dump,
  output logic [2:0]       status,
  output logic [7:0]       frame_length
);
  import hlfd_pkg::*;

  job_t push_job, head_job;
  logic push, push_ready, pop, head_valid;

  assign cfg_ready = 1'b1;
  assign in_ready  = push_ready;

  hlfd_front u_front (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .command, .speed, .program_value, .rx_byte,
    .push_job, .push
  );

  hlfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_job, .push_ready, .pop, .head_job, .head_valid
  );

  hlfd_back u_back (
    .clk, .rst, .head_job, .head_valid, .pop, .out_valid, .out_ready,
    .kind, .byte_value, .last, .is_dump, .status, .frame_length
  );

endmodule
`default_nettype wire
